FILE: rtl/cpbp_pkg.sv
// Package with the types, codes and tag tables of the constant pool byte parser.
package cpbp_pkg;

    // One input transaction: a stream byte or the end-of-data marker.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } cpbp_in_t;

    // One result transaction.
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] entry_number;
        logic [7:0]  tag;
        logic [15:0] first_index;
        logic [15:0] second_index;
        logic [63:0] payload;
        logic [3:0]  handle_kind;
        logic [7:0]  text_byte;
        logic [1:0]  error_code;
        logic        last;
    } cpbp_out_t;

    // Parser phases, one-hot.
    typedef enum logic [5:0] {
        PH_COUNT_HI = 6'b000001,
        PH_COUNT_LO = 6'b000010,
        PH_TAG      = 6'b000100,
        PH_FIELDS   = 6'b001000,
        PH_TEXT     = 6'b010000,
        PH_DRAIN    = 6'b100000
    } cpbp_phase_t;

    // Result kinds.
    localparam logic [2:0] KIND_ENTRY       = 3'd0;
    localparam logic [2:0] KIND_UTF8_HEADER = 3'd1;
    localparam logic [2:0] KIND_UTF8_BYTE   = 3'd2;
    localparam logic [2:0] KIND_ERROR       = 3'd3;
    localparam logic [2:0] KIND_EMPTY_POOL  = 3'd4;

    // Error codes.
    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN_TAG = 2'd1;
    localparam logic [1:0] ERR_BAD_REFKIND = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED   = 2'd3;

    // Constant pool tags.
    localparam logic [7:0] TAG_UTF8          = 8'd1;
    localparam logic [7:0] TAG_INTEGER       = 8'd3;
    localparam logic [7:0] TAG_FLOAT         = 8'd4;
    localparam logic [7:0] TAG_LONG          = 8'd5;
    localparam logic [7:0] TAG_DOUBLE        = 8'd6;
    localparam logic [7:0] TAG_CLASS         = 8'd7;
    localparam logic [7:0] TAG_STRING        = 8'd8;
    localparam logic [7:0] TAG_FIELDREF      = 8'd9;
    localparam logic [7:0] TAG_METHODREF     = 8'd10;
    localparam logic [7:0] TAG_IFMETHODREF   = 8'd11;
    localparam logic [7:0] TAG_NAME_AND_TYPE = 8'd12;
    localparam logic [7:0] TAG_METHOD_HANDLE = 8'd15;
    localparam logic [7:0] TAG_METHOD_TYPE   = 8'd16;
    localparam logic [7:0] TAG_INVOKEDYNAMIC = 8'd18;

    // Valid range of a method handle reference kind.
    localparam logic [7:0] REF_KIND_MIN = 8'd1;
    localparam logic [7:0] REF_KIND_MAX = 8'd9;

    // Smallest pool count that holds at least one entry.
    localparam logic [15:0] MIN_POOL_COUNT = 16'd2;

    // Number of fixed field bytes after a tag; zero marks an unknown tag.
    function automatic logic [3:0] field_length(input logic [7:0] tag);
        logic [3:0] len;
        case (tag)
            TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: len = 4'd2;
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
            TAG_IFMETHODREF, TAG_NAME_AND_TYPE, TAG_INVOKEDYNAMIC: len = 4'd4;
            TAG_LONG, TAG_DOUBLE: len = 4'd8;
            TAG_METHOD_HANDLE: len = 4'd3;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/cpbp_in_stage.sv
// Input register stage: holds one accepted transaction until the parser takes it.
module cpbp_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cpbp_pkg::cpbp_in_t s_data,
    output logic              item_valid,
    output cpbp_pkg::cpbp_in_t item,
    input  logic              item_take
);

    logic               valid_reg;
    cpbp_pkg::cpbp_in_t data_reg;

    // Room when empty or when the held item leaves this cycle.
    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload register.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

FILE: rtl/cpbp_parser.sv
// Parser state and the per-byte decode that produces at most one result.
module cpbp_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  cpbp_pkg::cpbp_in_t item,
    output logic               res_valid,
    output cpbp_pkg::cpbp_out_t res
);

    cpbp_pkg::cpbp_phase_t phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] slot_reg, slot_next;
    logic [7:0]  tag_reg, tag_next;
    logic [15:0] left_reg, left_next;
    logic [63:0] shift_reg, shift_next;

    logic [63:0] shift_in;
    logic [15:0] left_dec;
    logic [15:0] count_lo;
    logic [16:0] slot_plus1;
    logic [16:0] slot_plus2;
    logic        done1;
    logic        done2;
    logic [7:0]  ref_kind;
    logic [7:0]  b;

    assign b          = item.data_byte;
    assign shift_in   = {shift_reg[55:0], b};
    assign left_dec   = left_reg - 16'd1;
    assign count_lo   = {count_reg[15:8], b};
    assign slot_plus1 = {1'b0, slot_reg} + 17'd1;
    assign slot_plus2 = {1'b0, slot_reg} + 17'd2;
    assign done1      = slot_plus1 >= {1'b0, count_reg};
    assign done2      = slot_plus2 >= {1'b0, count_reg};
    assign ref_kind   = shift_in[23:16];

    // Next state and result for the byte at hand.
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        slot_next  = slot_reg;
        tag_next   = tag_reg;
        left_next  = left_reg;
        shift_next = shift_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.entry_number = slot_reg;

        if (item.end_of_data) begin
            // End of stream: report truncation unless the pool has already ended, then restart.
            if (phase_reg != cpbp_pkg::PH_DRAIN) begin
                res_valid      = 1'b1;
                res.kind       = cpbp_pkg::KIND_ERROR;
                res.tag        = tag_reg;
                res.error_code = cpbp_pkg::ERR_TRUNCATED;
                res.last       = 1'b1;
            end
            phase_next = cpbp_pkg::PH_COUNT_HI;
            count_next = '0;
            slot_next  = '0;
            tag_next   = '0;
            left_next  = '0;
            shift_next = '0;
        end else begin
            case (phase_reg)
                cpbp_pkg::PH_COUNT_HI: begin
                    count_next = {b, 8'h00};
                    phase_next = cpbp_pkg::PH_COUNT_LO;
                end
                cpbp_pkg::PH_COUNT_LO: begin
                    count_next = count_lo;
                    if (count_lo < cpbp_pkg::MIN_POOL_COUNT) begin
                        res_valid  = 1'b1;
                        res.kind   = cpbp_pkg::KIND_EMPTY_POOL;
                        res.last   = 1'b1;
                        phase_next = cpbp_pkg::PH_DRAIN;
                    end else begin
                        slot_next  = 16'd1;
                        phase_next = cpbp_pkg::PH_TAG;
                    end
                end
                cpbp_pkg::PH_TAG: begin
                    tag_next   = b;
                    left_next  = 16'(cpbp_pkg::field_length(b));
                    shift_next = '0;
                    if (cpbp_pkg::field_length(b) == 4'd0) begin
                        res_valid      = 1'b1;
                        res.kind       = cpbp_pkg::KIND_ERROR;
                        res.tag        = b;
                        res.error_code = cpbp_pkg::ERR_UNKNOWN_TAG;
                        res.last       = 1'b1;
                        phase_next     = cpbp_pkg::PH_DRAIN;
                    end else begin
                        phase_next = cpbp_pkg::PH_FIELDS;
                    end
                end
                cpbp_pkg::PH_FIELDS: begin
                    shift_next = shift_in;
                    left_next  = left_dec;
                    if (left_dec == 16'd0) begin
                        res_valid = 1'b1;
                        res.tag   = tag_reg;
                        if (tag_reg == cpbp_pkg::TAG_UTF8) begin
                            // Utf8 header; an empty string closes the entry here.
                            res.kind        = cpbp_pkg::KIND_UTF8_HEADER;
                            res.first_index = shift_in[15:0];
                            left_next       = shift_in[15:0];
                            if (shift_in[15:0] == 16'd0) begin
                                res.last = done1;
                                if (done1) begin
                                    phase_next = cpbp_pkg::PH_DRAIN;
                                end else begin
                                    slot_next  = slot_plus1[15:0];
                                    phase_next = cpbp_pkg::PH_TAG;
                                end
                            end else begin
                                phase_next = cpbp_pkg::PH_TEXT;
                            end
                        end else if (tag_reg == cpbp_pkg::TAG_METHOD_HANDLE &&
                                     (ref_kind < cpbp_pkg::REF_KIND_MIN ||
                                      ref_kind > cpbp_pkg::REF_KIND_MAX)) begin
                            res.kind       = cpbp_pkg::KIND_ERROR;
                            res.error_code = cpbp_pkg::ERR_BAD_REFKIND;
                            res.last       = 1'b1;
                            phase_next     = cpbp_pkg::PH_DRAIN;
                        end else if (tag_reg == cpbp_pkg::TAG_LONG ||
                                     tag_reg == cpbp_pkg::TAG_DOUBLE) begin
                            // Long and Double occupy two slots.
                            res.kind    = cpbp_pkg::KIND_ENTRY;
                            res.payload = shift_in;
                            res.last    = done2;
                            if (done2) begin
                                phase_next = cpbp_pkg::PH_DRAIN;
                            end else begin
                                slot_next  = slot_plus2[15:0];
                                phase_next = cpbp_pkg::PH_TAG;
                            end
                        end else begin
                            res.kind = cpbp_pkg::KIND_ENTRY;
                            res.last = done1;
                            case (tag_reg)
                                cpbp_pkg::TAG_METHOD_HANDLE: begin
                                    res.first_index = shift_in[15:0];
                                    res.handle_kind = ref_kind[3:0];
                                end
                                cpbp_pkg::TAG_INTEGER, cpbp_pkg::TAG_FLOAT: begin
                                    res.payload = {32'd0, shift_in[31:0]};
                                end
                                cpbp_pkg::TAG_CLASS, cpbp_pkg::TAG_STRING,
                                cpbp_pkg::TAG_METHOD_TYPE: begin
                                    res.first_index = shift_in[15:0];
                                end
                                default: begin
                                    res.first_index  = shift_in[31:16];
                                    res.second_index = shift_in[15:0];
                                end
                            endcase
                            if (done1) begin
                                phase_next = cpbp_pkg::PH_DRAIN;
                            end else begin
                                slot_next  = slot_plus1[15:0];
                                phase_next = cpbp_pkg::PH_TAG;
                            end
                        end
                    end
                end
                cpbp_pkg::PH_TEXT: begin
                    // One result per text byte; the final byte closes the entry.
                    left_next     = left_dec;
                    res_valid     = 1'b1;
                    res.kind      = cpbp_pkg::KIND_UTF8_BYTE;
                    res.tag       = cpbp_pkg::TAG_UTF8;
                    res.text_byte = b;
                    if (left_dec == 16'd0) begin
                        res.last = done1;
                        if (done1) begin
                            phase_next = cpbp_pkg::PH_DRAIN;
                        end else begin
                            slot_next  = slot_plus1[15:0];
                            phase_next = cpbp_pkg::PH_TAG;
                        end
                    end
                end
                default: begin
                    // Draining: bytes are dropped until end of data.
                end
            endcase
        end
    end

    // State registers, updated once per consumed byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= cpbp_pkg::PH_COUNT_HI;
            count_reg <= '0;
            slot_reg  <= '0;
            tag_reg   <= '0;
            left_reg  <= '0;
            shift_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            slot_reg  <= slot_next;
            tag_reg   <= tag_next;
            left_reg  <= left_next;
            shift_reg <= shift_next;
        end
    end

endmodule

FILE: rtl/cpbp_out_stage.sv
// Result register: holds one result transaction until the sink takes it.
module cpbp_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                res_valid,
    input  cpbp_pkg::cpbp_out_t res,
    output logic                free,
    output logic                m_valid,
    input  logic                m_ready,
    output cpbp_pkg::cpbp_out_t m_data
);

    logic                valid_reg;
    cpbp_pkg::cpbp_out_t data_reg;

    // The register can be loaded when empty or being emptied.
    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (step) begin
            valid_reg <= res_valid;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            data_reg <= res;
        end
    end

endmodule

FILE: rtl/constant_pool_byte_parser.sv
// Top level of the constant pool byte parser: input stage, parser and result stage.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_valid / s_ready    cpbp_in_t  (data_byte, end_of_data)
//   m_       out        m_valid / m_ready    cpbp_out_t (one result per transaction)
//
// One byte per cycle is sustained while the sink accepts results; each byte is held in the input
// register, and its result is loaded into the result register when the parser consumes it.
// The parser state advances only when the result register can take the outcome,
// so a stalled sink holds one byte in the input register and then drops s_ready.
// Reset is synchronous on aresetn and returns the parser to waiting for the count.
module constant_pool_byte_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cpbp_pkg::cpbp_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cpbp_pkg::cpbp_out_t m_data
);

    logic                item_valid;
    cpbp_pkg::cpbp_in_t  item;
    logic                step;
    logic                out_free;
    logic                res_valid;
    cpbp_pkg::cpbp_out_t res;

    // A byte is consumed when held and the result register has room.
    assign step = item_valid && out_free;

    cpbp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (step)
    );

    cpbp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    cpbp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: test/constant_pool_byte_parser_tb.sv
// Self-checking testbench for the constant pool byte parser with a built-in parse predictor.
`timescale 1ns / 1ps

module constant_pool_byte_parser_tb;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         LONG_HOLD      = 80;
    localparam int         TAIL_CYCLES    = 20;
    localparam logic [7:0] NO_TAG         = 8'h00;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    cpbp_pkg::cpbp_in_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    cpbp_pkg::cpbp_out_t m_data;

    constant_pool_byte_parser uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stream bytes waiting to be sent and parse results still to arrive.
    cpbp_pkg::cpbp_in_t  pending_bytes[$];
    cpbp_pkg::cpbp_out_t pool_results_due[$];
    logic [7:0]          seq_bytes[$];

    int  mismatch_count  = 0;
    int  bytes_taken     = 0;
    int  items_queued    = 0;
    int  idle_cycles     = 0;
    int  send_gap        = 0;
    int  recv_gap        = 0;
    int  hold_left       = 0;
    bit  long_hold_done  = 1'b0;
    bit  in_taken        = 1'b0;
    bit  stim_done       = 1'b0;
    wire idle_on         = (bytes_taken % 250) >= 60;

    // Predicted parser state.
    cpbp_pkg::cpbp_phase_t parse_phase;
    logic [15:0] pool_size;
    logic [15:0] slot_no;
    logic [15:0] remaining;
    logic [7:0]  cur_tag;
    logic [63:0] field_acc;

    // The closing stretch of the run, in which nobody idles.
    function automatic bit quiet_tail();
        return stim_done && (pending_bytes.size() < 120);
    endfunction

    // Queue appends.
    task automatic due_add(input cpbp_pkg::cpbp_out_t r);
        pool_results_due.insert(pool_results_due.size(), r);
    endtask

    task automatic seq_add(input logic [7:0] b);
        seq_bytes.insert(seq_bytes.size(), b);
    endtask

    task automatic pending_add(input cpbp_pkg::cpbp_in_t it);
        pending_bytes.insert(pending_bytes.size(), it);
    endtask

    // Fixed field bytes that follow a tag; zero means the tag is not defined.
    function automatic int entry_field_bytes(input logic [7:0] tag);
        case (tag)
            cpbp_pkg::TAG_LONG, cpbp_pkg::TAG_DOUBLE: return 8;
            cpbp_pkg::TAG_INTEGER, cpbp_pkg::TAG_FLOAT, cpbp_pkg::TAG_FIELDREF,
            cpbp_pkg::TAG_METHODREF, cpbp_pkg::TAG_IFMETHODREF,
            cpbp_pkg::TAG_NAME_AND_TYPE, cpbp_pkg::TAG_INVOKEDYNAMIC: return 4;
            cpbp_pkg::TAG_METHOD_HANDLE: return 3;
            cpbp_pkg::TAG_UTF8, cpbp_pkg::TAG_CLASS, cpbp_pkg::TAG_STRING,
            cpbp_pkg::TAG_METHOD_TYPE: return 2;
            default: return 0;
        endcase
    endfunction

    // A result with every unused field cleared and the current slot number.
    function automatic cpbp_pkg::cpbp_out_t blank_result(input logic [2:0] kind,
                                                         input logic [7:0] tag,
                                                         input logic last);
        cpbp_pkg::cpbp_out_t r;
        r              = '0;
        r.kind         = kind;
        r.entry_number = slot_no;
        r.tag          = tag;
        r.last         = last;
        return r;
    endfunction

    task automatic restart_parse();
        parse_phase = cpbp_pkg::PH_COUNT_HI;
        pool_size   = '0;
        slot_no     = '0;
        remaining   = '0;
        cur_tag     = NO_TAG;
        field_acc   = '0;
    endtask

    // An error ends the pool; bytes are dropped until end of data.
    task automatic raise_error(input logic [7:0] tag, input logic [1:0] code);
        cpbp_pkg::cpbp_out_t r;
        r            = blank_result(cpbp_pkg::KIND_ERROR, tag, 1'b1);
        r.error_code = code;
        due_add(r);
        parse_phase  = cpbp_pkg::PH_DRAIN;
    endtask

    // Emit the final result of an entry and step past its slots.
    task automatic close_entry(input cpbp_pkg::cpbp_out_t r, input int slots);
        r.last = ({1'b0, slot_no} + 17'(slots)) >= {1'b0, pool_size};
        due_add(r);
        if (r.last) begin
            parse_phase = cpbp_pkg::PH_DRAIN;
        end else begin
            slot_no     = slot_no + 16'(slots);
            parse_phase = cpbp_pkg::PH_TAG;
        end
    endtask

    // All fixed fields of the current entry are in.
    task automatic finish_entry();
        cpbp_pkg::cpbp_out_t r;
        logic [7:0]          ref_kind;
        r        = blank_result(cpbp_pkg::KIND_ENTRY, cur_tag, 1'b0);
        ref_kind = field_acc[23:16];
        case (cur_tag)
            cpbp_pkg::TAG_UTF8: begin
                r.kind = cpbp_pkg::KIND_UTF8_HEADER;
                if (field_acc[15:0] == 16'd0) begin
                    close_entry(r, 1);
                end else begin
                    r.first_index = field_acc[15:0];
                    due_add(r);
                    remaining   = field_acc[15:0];
                    parse_phase = cpbp_pkg::PH_TEXT;
                end
            end
            cpbp_pkg::TAG_METHOD_HANDLE: begin
                if (ref_kind < cpbp_pkg::REF_KIND_MIN || ref_kind > cpbp_pkg::REF_KIND_MAX) begin
                    raise_error(cur_tag, cpbp_pkg::ERR_BAD_REFKIND);
                end else begin
                    r.first_index = field_acc[15:0];
                    r.handle_kind = ref_kind[3:0];
                    close_entry(r, 1);
                end
            end
            cpbp_pkg::TAG_LONG, cpbp_pkg::TAG_DOUBLE: begin
                r.payload = field_acc;
                close_entry(r, 2);
            end
            cpbp_pkg::TAG_INTEGER, cpbp_pkg::TAG_FLOAT: begin
                r.payload = {32'h0, field_acc[31:0]};
                close_entry(r, 1);
            end
            cpbp_pkg::TAG_CLASS, cpbp_pkg::TAG_STRING, cpbp_pkg::TAG_METHOD_TYPE: begin
                r.first_index = field_acc[15:0];
                close_entry(r, 1);
            end
            default: begin
                r.first_index  = field_acc[31:16];
                r.second_index = field_acc[15:0];
                close_entry(r, 1);
            end
        endcase
    endtask

    // Work out the results that one accepted input transaction causes.
    task automatic parse_byte(input cpbp_pkg::cpbp_in_t item);
        cpbp_pkg::cpbp_out_t r;
        logic [7:0]          b;
        b = item.data_byte;
        if (item.end_of_data) begin
            if (parse_phase != cpbp_pkg::PH_DRAIN) begin
                raise_error(cur_tag, cpbp_pkg::ERR_TRUNCATED);
            end
            restart_parse();
        end else begin
            case (parse_phase)
                cpbp_pkg::PH_COUNT_HI: begin
                    pool_size   = {b, 8'h00};
                    parse_phase = cpbp_pkg::PH_COUNT_LO;
                end
                cpbp_pkg::PH_COUNT_LO: begin
                    pool_size[7:0] = b;
                    if (pool_size < cpbp_pkg::MIN_POOL_COUNT) begin
                        due_add(blank_result(cpbp_pkg::KIND_EMPTY_POOL, NO_TAG, 1'b1));
                        parse_phase = cpbp_pkg::PH_DRAIN;
                    end else begin
                        slot_no     = 16'd1;
                        parse_phase = cpbp_pkg::PH_TAG;
                    end
                end
                cpbp_pkg::PH_TAG: begin
                    cur_tag   = b;
                    remaining = 16'(entry_field_bytes(b));
                    field_acc = '0;
                    if (remaining == 16'd0) begin
                        raise_error(b, cpbp_pkg::ERR_UNKNOWN_TAG);
                    end else begin
                        parse_phase = cpbp_pkg::PH_FIELDS;
                    end
                end
                cpbp_pkg::PH_FIELDS: begin
                    field_acc = {field_acc[55:0], b};
                    remaining = remaining - 16'd1;
                    if (remaining == 16'd0) begin
                        finish_entry();
                    end
                end
                cpbp_pkg::PH_TEXT: begin
                    r           = blank_result(cpbp_pkg::KIND_UTF8_BYTE, cpbp_pkg::TAG_UTF8,
                                               1'b0);
                    r.text_byte = b;
                    remaining   = remaining - 16'd1;
                    if (remaining == 16'd0) begin
                        close_entry(r, 1);
                    end else begin
                        due_add(r);
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
        end
    endtask

    // Acceptance on both channels, result checking and the watchdog.
    always @(posedge aclk) begin : monitor_blk
        cpbp_pkg::cpbp_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                parse_byte(s_data);
                in_taken = 1'b1;
                bytes_taken++;
            end
            if (m_valid && m_ready) begin
                if (pool_results_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, m_data);
                end else begin
                    want = pool_results_due.pop_front();
                    check_field("kind", want.kind, m_data.kind);
                    check_field("entry_number", want.entry_number, m_data.entry_number);
                    check_field("tag", want.tag, m_data.tag);
                    check_field("first_index", want.first_index, m_data.first_index);
                    check_field("second_index", want.second_index, m_data.second_index);
                    check_field("payload", want.payload, m_data.payload);
                    check_field("handle_kind", want.handle_kind, m_data.handle_kind);
                    check_field("text_byte", want.text_byte, m_data.text_byte);
                    check_field("error_code", want.error_code, m_data.error_code);
                    check_field("last", want.last, m_data.last);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("constant_pool_byte_parser_tb: errors");
                $finish;
            end
        end
    end

    // Input driver: holds a transaction until accepted, otherwise idles in bursts or sends.
    always @(negedge aclk) begin : driver_blk
        bit keep;
        keep     = s_valid && !in_taken;
        in_taken = 1'b0;
        if (!keep) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (aresetn && pending_bytes.size() != 0) begin
                if (!quiet_tail() && idle_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 5);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_data  <= pending_bytes.pop_front();
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stall bursts plus one long hold that backs up the block.
    always @(negedge aclk) begin
        if (!long_hold_done && bytes_taken >= 400) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else if (!quiet_tail() && idle_on && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        cpbp_pkg::cpbp_in_t it;
        it.data_byte   = b;
        it.end_of_data = 1'b0;
        pending_add(it);
        items_queued++;
    endtask

    // End of data carries a random byte that the block must ignore.
    task automatic queue_end();
        cpbp_pkg::cpbp_in_t it;
        it.data_byte   = 8'($urandom);
        it.end_of_data = 1'b1;
        pending_add(it);
        items_queued++;
    endtask

    task automatic add_u16(input logic [15:0] v);
        seq_add(v[15:8]);
        seq_add(v[7:0]);
    endtask

    task automatic add_random(input int n);
        repeat (n) seq_add(8'($urandom));
    endtask

    function automatic logic [7:0] pick_tag();
        case ($urandom_range(0, 13))
            0:       return cpbp_pkg::TAG_UTF8;
            1:       return cpbp_pkg::TAG_INTEGER;
            2:       return cpbp_pkg::TAG_FLOAT;
            3:       return cpbp_pkg::TAG_LONG;
            4:       return cpbp_pkg::TAG_DOUBLE;
            5:       return cpbp_pkg::TAG_CLASS;
            6:       return cpbp_pkg::TAG_STRING;
            7:       return cpbp_pkg::TAG_FIELDREF;
            8:       return cpbp_pkg::TAG_METHODREF;
            9:       return cpbp_pkg::TAG_IFMETHODREF;
            10:      return cpbp_pkg::TAG_NAME_AND_TYPE;
            11:      return cpbp_pkg::TAG_METHOD_HANDLE;
            12:      return cpbp_pkg::TAG_METHOD_TYPE;
            default: return cpbp_pkg::TAG_INVOKEDYNAMIC;
        endcase
    endfunction

    // Append one well-formed entry with random contents; reports the slots it takes.
    task automatic add_entry(input logic [7:0] tag, output int slots);
        int         len;
        logic [7:0] ref_kind;
        slots = 1;
        seq_add(tag);
        case (tag)
            cpbp_pkg::TAG_UTF8: begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 4);
                add_u16(16'(len));
                add_random(len);
            end
            cpbp_pkg::TAG_METHOD_HANDLE: begin
                // Mostly legal reference kinds, now and then one outside the range.
                if ($urandom_range(0, 9) == 0) begin
                    ref_kind = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(10, 255));
                end else begin
                    ref_kind = 8'($urandom_range(1, 9));
                end
                seq_add(ref_kind);
                add_random(2);
            end
            cpbp_pkg::TAG_LONG, cpbp_pkg::TAG_DOUBLE: begin
                add_random(8);
                slots = 2;
            end
            default: add_random(entry_field_bytes(tag));
        endcase
    endtask

    task automatic build_pool(input logic [15:0] count);
        int slot;
        int used;
        add_u16(count);
        slot = 1;
        while (slot < count) begin
            add_entry(pick_tag(), used);
            slot += used;
        end
    endtask

    task automatic flush_sequence();
        foreach (seq_bytes[i]) queue_byte(seq_bytes[i]);
        queue_end();
        seq_bytes.delete();
    endtask

    // Checked at rising edges, where the driver never changes the queue or s_valid.
    task automatic wait_drained();
        @(posedge aclk);
        while (pending_bytes.size() != 0 || s_valid || pool_results_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin : stimulus
        int          pick;
        int          cut;
        int          used;
        logic [7:0]  odd_tag;
        logic [15:0] count;

        restart_parse();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Stream ends with no bytes at all.
        queue_end();
        // A count of one is an empty pool; the trailing byte is ignored.
        queue_byte(8'h00);
        queue_byte(8'h01);
        queue_byte(8'hFF);
        queue_end();
        // Undefined tag in the first slot.
        queue_byte(8'h00);
        queue_byte(8'h02);
        queue_byte(8'h02);
        queue_end();
        // Double with an all-ones payload fills the final slot and ends the pool.
        queue_byte(8'h00);
        queue_byte(8'h03);
        queue_byte(cpbp_pkg::TAG_DOUBLE);
        repeat (8) queue_byte(8'hFF);
        queue_end();
        // Method handle with reference kind ten in a pool of the largest count.
        queue_byte(8'hFF);
        queue_byte(8'hFF);
        queue_byte(cpbp_pkg::TAG_METHOD_HANDLE);
        queue_byte(8'h0A);
        queue_byte(8'h00);
        queue_byte(8'h01);
        queue_end();

        // Sender pauses until every result of the directed part has come back.
        wait_drained();

        while (items_queued < 1120) begin
            pick  = $urandom_range(0, 19);
            count = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(11, 40))
                                                : 16'($urandom_range(2, 10));
            if (pick <= 13) begin
                // Well-formed pool, sometimes followed by bytes that must be ignored.
                build_pool(count);
                if ($urandom_range(0, 4) == 0) add_random($urandom_range(1, 4));
            end else if (pick == 14) begin
                // Empty pool.
                add_u16(16'($urandom_range(0, 1)));
                add_random($urandom_range(0, 2));
            end else if (pick <= 16) begin
                // Pool cut short before its last byte.
                build_pool(count);
                cut = $urandom_range(0, seq_bytes.size() - 1);
                while (seq_bytes.size() > cut) void'(seq_bytes.pop_back());
            end else if (pick == 17) begin
                // Utf8 entry announcing a long text, cut off early.
                add_u16(16'($urandom_range(2, 65535)));
                seq_add(cpbp_pkg::TAG_UTF8);
                add_u16(16'($urandom));
                add_random($urandom_range(0, 6));
            end else if (pick == 18) begin
                // Undefined tag after up to three good entries.
                add_u16(16'($urandom_range(2, 65535)));
                repeat ($urandom_range(0, 3)) add_entry(pick_tag(), used);
                do begin
                    odd_tag = 8'($urandom);
                end while (entry_field_bytes(odd_tag) != 0);
                seq_add(odd_tag);
                add_random($urandom_range(0, 3));
            end else begin
                // Raw noise with stray end-of-data transactions.
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        queue_end();
                    end else begin
                        queue_byte(8'($urandom));
                    end
                end
            end
            flush_sequence();
        end
        stim_done = 1'b1;

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (pool_results_due.size() != 0) begin
            mismatch_count++;
            $display("%0t: missing results, expected %0d more, actual none",
                     $time, pool_results_due.size());
        end
        if (mismatch_count == 0) begin
            $display("constant_pool_byte_parser_tb: clean");
        end else begin
            $display("constant_pool_byte_parser_tb: errors");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/cpbp_pkg.sv
rtl/cpbp_in_stage.sv
rtl/cpbp_parser.sv
rtl/cpbp_out_stage.sv
rtl/constant_pool_byte_parser.sv
test/constant_pool_byte_parser_tb.sv
